@@ rtl/ptw_pkg.sv @@
package ptw_pkg;

   // Default size of the local table store, in 64-bit words.
   localparam int unsigned PTW_MEM_WORDS = 4096;

   localparam int unsigned WORD_W    = 64;
   localparam int unsigned VADDR_W   = 48;
   localparam int unsigned PADDR_W   = 52;
   localparam int unsigned FRAME_W   = 40;   // entry bits 51:12
   localparam int unsigned SLICE_W   = 9;
   localparam int unsigned OFFSET_W  = 12;
   localparam int unsigned WIDX_W    = 12;
   localparam int unsigned WADDR_W   = FRAME_W + SLICE_W;
   localparam int unsigned LEVELS    = 4;
   localparam int unsigned LVL_W     = $clog2(LEVELS);

   typedef enum logic [1:0] {
      FUNC_TRANSLATE = 2'd0,
      FUNC_WRITE     = 2'd1,
      FUNC_UNMAP     = 2'd2
   } func_type;

   // Nine-bit table index for the given level, top level first.
   function automatic logic [SLICE_W-1:0] ptw_slice(input logic [VADDR_W-1:0] va,
                                                    input logic [LVL_W-1:0]   lvl);
      logic [SLICE_W-1:0] s;
      case (lvl)
         2'd0:    s = va[47:39];
         2'd1:    s = va[38:30];
         2'd2:    s = va[29:21];
         2'd3:    s = va[20:12];
         default: s = va[20:12];
      endcase
      return s;
   endfunction

endpackage

@@ rtl/ptw_ram.sv @@
module ptw_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/four_level_page_table_walker.sv @@
// Four-level page-table walker with a local store of 64-bit table words.
//
// The request channel (req_) carries one word per operation: tuser holds the
// operation (translate, write table word, unmap) and tdata the virtual
// address, the store index and the word to write. The response channel
// (rsp_) returns exactly one word per request: the physical address in tdata
// and the mapped flag in tuser. The user must write the root table address
// via csr_wr_en/csr_wr_data only while idle; the block does not enforce it.
//
// A table write's response is registered at once, so writes can follow one
// per cycle while each response is taken. A translate or unmap uses one
// shared address/range unit and the single read port of the store: per level
// it checks the word address and reads, then tests the entry; a last state
// loads the response (sooner when a level is absent), and only then, back in
// idle, is a new request taken. One operation is in flight at a time.
//
// After reset the store is swept to zero, one word a cycle, so req_tready
// stays low until the sweep ends. A response held by a stalled receiver
// sits in the output register; the block takes the next request only once
// that register is free or being emptied in the same cycle.
module four_level_page_table_walker
   import ptw_pkg::*;
#(
   parameter int unsigned MEM_WORDS = PTW_MEM_WORDS
) (
   input  logic         clock,
   input  logic         reset,
   // Request: [47:0] virtual address, [59:48] word_index, [123:60] word_data.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,
   // Request: [1:0] func.
   input  logic [1:0]   req_tuser,
   // Response: [51:0] physical address.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,
   // Response: [0] mapped.
   output logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [51:0]  csr_wr_data
);

   localparam int unsigned AW = $clog2(MEM_WORDS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_FETCH,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [PADDR_W-1:0]   root_ff, root_in;
   func_type             func_ff, func_in;
   logic [VADDR_W-1:0]   va_ff, va_in;
   logic [FRAME_W-1:0]   base_ff, base_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   logic [AW-1:0]        leaf_ff, leaf_in;
   logic [PADDR_W-1:0]   res_phys_ff, res_phys_in;
   logic                 res_mapped_ff, res_mapped_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [PADDR_W-1:0]   rsp_phys_ff, rsp_phys_in;
   logic                 rsp_mapped_ff, rsp_mapped_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_W-1:0]    ram_wdata;
   logic                 ram_re;
   logic [WORD_W-1:0]    ram_rdata;

   logic [WADDR_W-1:0]   walk_addr;
   logic                 walk_in_range;
   logic [WADDR_W-1:0]   widx_wide;
   logic                 rsp_free;
   logic                 req_fire;

   // Shared address unit: frame of the current table joined with the slice,
   // then checked against the size of the store.
   assign walk_addr     = {base_ff, ptw_slice(va_ff, lvl_ff)};
   assign walk_in_range = walk_addr < WADDR_W'(MEM_WORDS);
   assign widx_wide     = WADDR_W'(req_tdata[59:48]);

   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      root_in       = root_ff;
      func_in       = func_ff;
      va_in         = va_ff;
      base_in       = base_ff;
      lvl_in        = lvl_ff;
      leaf_in       = leaf_ff;
      res_phys_in   = res_phys_ff;
      res_mapped_in = res_mapped_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_phys_in   = rsp_phys_ff;
      rsp_mapped_in = rsp_mapped_ff;
      ram_we        = 1'b0;
      ram_waddr     = leaf_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (csr_wr_en) begin
         root_in = csr_wr_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               func_in = func_type'(req_tuser);
               va_in   = req_tdata[47:0];
               base_in = root_ff[PADDR_W-1:OFFSET_W];
               lvl_in  = '0;
               case (req_tuser)
                  FUNC_TRANSLATE, FUNC_UNMAP: begin
                     state_in = ST_LOOK;
                  end
                  FUNC_WRITE: begin
                     // Writes beyond the store are dropped.
                     ram_we        = widx_wide < WADDR_W'(MEM_WORDS);
                     ram_waddr     = AW'(widx_wide);
                     ram_wdata     = req_tdata[123:60];
                     rsp_tvalid_in = 1'b1;
                     rsp_phys_in   = '0;
                     rsp_mapped_in = 1'b0;
                  end
                  default: begin
                     rsp_tvalid_in = 1'b1;
                     rsp_phys_in   = '0;
                     rsp_mapped_in = 1'b0;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (walk_in_range) begin
               ram_re   = 1'b1;
               leaf_in  = AW'(walk_addr);
               state_in = ST_FETCH;
            end else begin
               // A table word outside the store reads as zero: not present.
               res_phys_in   = '0;
               res_mapped_in = 1'b0;
               state_in      = ST_FINISH;
            end
         end
         ST_FETCH: begin
            if (!ram_rdata[0]) begin
               res_phys_in   = '0;
               res_mapped_in = 1'b0;
               state_in      = ST_FINISH;
            end else if (lvl_ff == LVL_W'(LEVELS - 1)) begin
               res_mapped_in = 1'b1;
               if (func_ff == FUNC_UNMAP) begin
                  ram_we      = 1'b1;
                  res_phys_in = '0;
               end else begin
                  res_phys_in = {ram_rdata[PADDR_W-1:OFFSET_W], va_ff[OFFSET_W-1:0]};
               end
               state_in = ST_FINISH;
            end else begin
               base_in  = ram_rdata[PADDR_W-1:OFFSET_W];
               lvl_in   = lvl_ff + 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_phys_in   = res_phys_ff;
               rsp_mapped_in = res_mapped_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         root_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         root_ff       <= root_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      func_ff       <= func_in;
      va_ff         <= va_in;
      base_ff       <= base_in;
      lvl_ff        <= lvl_in;
      leaf_ff       <= leaf_in;
      res_phys_ff   <= res_phys_in;
      res_mapped_ff <= res_mapped_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_mapped_ff <= rsp_mapped_in;
   end

   ptw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (AW'(walk_addr)),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0, rsp_phys_ff};
   assign rsp_tuser  = rsp_mapped_ff;

   // An unmapped result never carries an address.
   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("unmapped response with non-zero address");

   // During a walk the store is only written to clear an unmapped leaf.
   a_walk_write: assert property (@(posedge clock) disable iff (reset)
      ram_we && state_ff != ST_CLEAR && state_ff != ST_IDLE
      |-> ram_wdata == '0 && func_ff == FUNC_UNMAP && state_ff == ST_FETCH)
      else $error("unexpected store write during walk");

   // Read data is consumed only in the cycle after the read was issued.
   a_fetch_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> $past(state_ff) == ST_LOOK && $past(ram_re))
      else $error("fetch without a preceding read");

   // No response is produced while the store is being cleared.
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_tvalid && !req_tready)
      else $error("activity during clearing sweep");

endmodule

@@ verif/ptw_walk_monitor.sv @@
module ptw_walk_monitor
   import ptw_pkg::*;
#(
   parameter int unsigned MEM_WORDS = PTW_MEM_WORDS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [55:0]  rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [51:0]  csr_wr_data,
   output int           errors,
   output int           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [WORD_W-1:0] FRAME_BITS = 64'h000F_FFFF_FFFF_F000;

   typedef struct packed {
      logic [PADDR_W-1:0] phys;
      logic               mapped;
   } xlat_result_type;

   xlat_result_type   pending_results[$];
   xlat_result_type   oldest;
   logic [WORD_W-1:0] table_store [MEM_WORDS];
   logic [PADDR_W-1:0] root_addr;
   int                fail_count = 0;
   int                queued = 0;

   assign errors      = fail_count;
   assign outstanding = queued;

   // Four dependent reads, top level first. Returns 1 with the leaf's word address
   // and value when every entry on the way has its present bit set.
   function automatic bit walk_tables(input  logic [VADDR_W-1:0] va,
                                      output logic [WORD_W-1:0]  leaf_addr,
                                      output logic [WORD_W-1:0]  leaf_val);
      logic [WORD_W-1:0]  base;
      logic [WORD_W-1:0]  waddr;
      logic [WORD_W-1:0]  entry;
      logic [SLICE_W-1:0] slice;
      base      = 64'(root_addr);
      leaf_addr = '0;
      leaf_val  = '0;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         slice = va[39 - 9 * lvl +: SLICE_W];
         waddr = ((base & FRAME_BITS) >> 3) + 64'(slice);
         // Words past the end of the store read as zero, so never present.
         entry = (waddr < 64'(MEM_WORDS)) ? table_store[waddr] : '0;
         if (!entry[0]) begin
            return 1'b0;
         end
         base      = entry & FRAME_BITS;
         leaf_addr = waddr;
         leaf_val  = entry;
      end
      return 1'b1;
   endfunction

   function automatic xlat_result_type predict_walk_result(input logic [1:0]         op,
                                                           input logic [VADDR_W-1:0] va,
                                                           input logic [WIDX_W-1:0]  widx,
                                                           input logic [WORD_W-1:0]  wdata);
      xlat_result_type   res;
      logic [WORD_W-1:0] leaf_addr;
      logic [WORD_W-1:0] leaf_val;
      res = '0;
      case (op)
         FUNC_TRANSLATE: begin
            if (walk_tables(va, leaf_addr, leaf_val)) begin
               res.phys   = {leaf_val[51:12], va[11:0]};
               res.mapped = 1'b1;
            end
         end
         FUNC_WRITE: begin
            if (32'(widx) < MEM_WORDS) begin
               table_store[widx] = wdata;
            end
         end
         FUNC_UNMAP: begin
            if (walk_tables(va, leaf_addr, leaf_val) && leaf_addr < 64'(MEM_WORDS)) begin
               table_store[leaf_addr] = '0;
               res.mapped = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (table_store[i]) begin
            table_store[i] = '0;
         end
         root_addr = '0;
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            root_addr = csr_wr_data;
         end
         // A response word can only belong to an earlier request, so it is matched first.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("response word with nothing outstanding: paddr %h mapped %b",
                      rsp_tdata[PADDR_W-1:0], rsp_tuser);
               fail_count++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_tdata[PADDR_W-1:0] !== oldest.phys) begin
                  $error("paddr: expected %h, actual %h",
                         oldest.phys, rsp_tdata[PADDR_W-1:0]);
                  fail_count++;
               end
               if (rsp_tuser !== oldest.mapped) begin
                  $error("mapped: expected %b, actual %b", oldest.mapped, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.push_back(predict_walk_result(req_tuser, req_tdata[47:0],
                                                          req_tdata[59:48],
                                                          req_tdata[123:60]));
         end
      end
      queued = pending_results.size();
   end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
   import ptw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 250000;
   localparam int         DRAIN_CYCLES = 12;
   localparam int         TARGET_ITEMS = 550;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [51:0]  csr_wr_data = '0;

   int           errors;
   int           outstanding;
   int           items_sent = 0;
   int           cycle_count = 0;
   int           ready_left = 0;
   logic         calm = 1'b0;
   logic         hold_go = 1'b0;
   logic         holding = 1'b0;

   four_level_page_table_walker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ptw_walk_monitor u_walk_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: random bursts of ready and stall, none in the closing phase.
   always @(posedge clock) begin
      if (holding) begin
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if (ready_left > 0) begin
         ready_left <= ready_left - 1;
      end else begin
         rsp_tready <= 1'($urandom_range(0, 1));
         ready_left <= $urandom_range(1, 18);
      end
   end

   // One long hold-off so the output register fills and the request side backs up.
   initial begin
      wait (hold_go);
      @(posedge clock);
      holding <= 1'b1;
      repeat (300) @(posedge clock);
      holding <= 1'b0;
   end

   function automatic logic [VADDR_W-1:0] rand_va();
      return {16'($urandom), $urandom};
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Page-table entry for the given frame and present bit; other flag and upper bits are random.
   function automatic logic [WORD_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
                                                    input logic               present);
      logic [WORD_W-1:0] e;
      e        = rand_word();
      e[51:12] = frame;
      e[0]     = present;
      return e;
   endfunction

   // Mostly a table page inside the store, now and then one just past it or far away.
   function automatic logic [FRAME_W-1:0] pick_table_page();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) begin
         return 40'd8;
      end
      if (r == 1) begin
         return {8'($urandom), $urandom};
      end
      return 40'($urandom_range(0, 7));
   endfunction

   task automatic send_req(input logic [1:0]         op,
                           input logic [VADDR_W-1:0] va,
                           input logic [WIDX_W-1:0]  widx,
                           input logic [WORD_W-1:0]  wdata);
      int gap;
      if (!calm && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, wdata, widx, va};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic write_word(input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] data);
      send_req(FUNC_WRITE, rand_va(), widx, data);
   endtask

   task automatic translate(input logic [VADDR_W-1:0] va);
      send_req(FUNC_TRANSLATE, va, 12'($urandom), rand_word());
   endtask

   task automatic unmap(input logic [VADDR_W-1:0] va);
      send_req(FUNC_UNMAP, va, 12'($urandom), rand_word());
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_root(input logic [PADDR_W-1:0] addr);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= addr;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Builds a four-level path for a random address, sometimes with one level
   // left absent, then walks it and possibly tears the leaf down again.
   task automatic map_and_walk(input logic [FRAME_W-1:0] root_pg);
      logic [VADDR_W-1:0] va;
      logic [FRAME_W-1:0] p3;
      logic [FRAME_W-1:0] p2;
      logic [FRAME_W-1:0] p1;
      logic [FRAME_W-1:0] frame;
      int                 broken;
      va     = rand_va();
      p3     = pick_table_page();
      p2     = pick_table_page();
      p1     = pick_table_page();
      frame  = {8'($urandom), $urandom};
      broken = $urandom_range(0, 9);
      write_word({root_pg[2:0], va[47:39]}, make_entry(p3, broken != 0));
      write_word({p3[2:0], va[38:30]}, make_entry(p2, broken != 1));
      write_word({p2[2:0], va[29:21]}, make_entry(p1, broken != 2));
      write_word({p1[2:0], va[20:12]}, make_entry(frame, broken != 3));
      translate(va);
      if ($urandom_range(0, 1) == 1) begin
         translate({va[47:12], 12'($urandom)});
      end
      if ($urandom_range(0, 1) == 1) begin
         unmap(va);
         translate(va);
      end
   endtask

   task automatic run_phase(input logic [FRAME_W-1:0] root_pg, input int n);
      int phase_end;
      phase_end = items_sent + n;
      while (items_sent < phase_end) begin
         if ($urandom_range(0, 4) == 0) begin
            send_req(2'($urandom_range(0, 3)), rand_va(), 12'($urandom), rand_word());
         end else begin
            map_and_walk(root_pg);
         end
      end
   endtask

   initial begin
      logic [FRAME_W-1:0] root_pg;
      int                 phase;
      wait (!reset);
      @(posedge clock);

      // Root still at its reset value of zero; the store is empty.
      translate('0);
      translate('1);
      unmap('0);
      send_req(FUNC_UNUSED, '1, '1, '1);
      // A present top entry whose frame lies far beyond the store.
      write_word(12'd0, '1);
      translate('0);
      unmap('0);
      // Full path through pages 1 to 3 to a leaf with every frame bit set.
      write_word(12'd0, 64'h1001);
      write_word(12'd512, 64'h2001);
      write_word(12'd1024, 64'h3001);
      write_word(12'd1536, '1);
      translate(48'hFFF);
      translate('0);
      write_word(12'd1024, 64'h3000);
      translate('0);
      write_word(12'd1024, 64'h3001);
      unmap(48'hABC);
      translate(48'hABC);
      unmap('0);
      write_word(12'd4095, '0);
      write_word(12'd511, 64'h7001);
      write_word(12'd4095, '1);
      translate('1);
      send_req(FUNC_UNUSED, '0, '0, '0);

      // Root beyond the store: nothing can be found.
      wait_for_drain();
      root_pg = '1;
      set_root('1);
      run_phase(root_pg, 25);

      wait_for_drain();
      root_pg = '0;
      set_root(52'h0_0000_0000_0FFF);
      run_phase(root_pg, 40);

      phase = 0;
      while (items_sent < TARGET_ITEMS - 70) begin
         wait_for_drain();
         root_pg = 40'($urandom_range(0, 7));
         set_root({root_pg, 12'($urandom)});
         if (phase == 1) begin
            hold_go <= 1'b1;
         end
         run_phase(root_pg, $urandom_range(30, 70));
         phase++;
      end

      wait_for_drain();
      calm    <= 1'b1;
      root_pg = 40'd7;
      set_root({root_pg, 12'hFFF});
      run_phase(root_pg, 60);

      wait_for_drain();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ptw_pkg.sv
rtl/ptw_ram.sv
rtl/four_level_page_table_walker.sv
verif/ptw_walk_monitor.sv
verif/tb_top.sv
